FILE: sv/omo_pkg.sv
// shared types, constants and tables of the omni odometry block
`default_nettype none
package omo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int QDEPTH = 2;

  localparam logic [31:0] ONE_Q24 = 32'h0100_0000;
  localparam logic signed [33:0] KINV_Q30 = 34'sd652032874;
  // inverse of 45 modulo 2^32, for exact division by 45
  localparam logic [31:0] INV45 = 32'hA4FA_4FA5;
  // ceil(2^18 / 45)
  localparam logic [12:0] RECIP45 = 13'd5826;

  localparam logic [1:0] REG_X_COEF = 2'd0;
  localparam logic [1:0] REG_Y_COEF = 2'd1;
  localparam logic [1:0] REG_HEAD_COEF = 2'd2;

  typedef struct packed {
    logic signed [31:0] count_a;
    logic signed [31:0] count_b;
    logic signed [31:0] count_c;
  } omo_in_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [31:0] heading;
  } omo_out_t;

  typedef struct packed {
    logic signed [31:0] comb_x;
    logic signed [31:0] comb_y;
    logic signed [33:0] sum;
  } omo_job_t;

  typedef struct packed {
    logic signed [31:0] x_coef;
    logic signed [31:0] y_coef;
    logic signed [31:0] heading_coef;
  } omo_cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MX, ST_MY, ST_H0, ST_H1, ST_H2, ST_MOD, ST_MODR, ST_HD,
    ST_DF, ST_DR, ST_DM, ST_FOLD, ST_CORD, ST_R0, ST_R1, ST_R2, ST_R3, ST_ACC
  } omo_state_t;

  function automatic logic signed [33:0] atan_q(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0: v = 34'sd536870912;
      5'd1: v = 34'sd316933406;
      5'd2: v = 34'sd167458907;
      5'd3: v = 34'sd85004756;
      5'd4: v = 34'sd42667332;
      5'd5: v = 34'sd21354465;
      5'd6: v = 34'sd10679838;
      5'd7: v = 34'sd5340245;
      5'd8: v = 34'sd2670163;
      5'd9: v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10431;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      5'd24: v = 34'sd41;
      5'd25: v = 34'sd20;
      5'd26: v = 34'sd10;
      5'd27: v = 34'sd5;
      5'd28: v = 34'sd3;
      5'd29: v = 34'sd1;
      5'd30: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sh7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -72'sh8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // 2^12 is 1 mod 45, so 12-bit chunks add up to the same residue
  function automatic logic [11:0] fold45(input logic [47:0] v);
    logic [13:0] s1;
    logic [12:0] s2;
    logic [11:0] s3;
    s1 = 14'(v[11:0]) + 14'(v[23:12]) + 14'(v[35:24]) + 14'(v[47:36]);
    s2 = 13'(s1[11:0]) + 13'(s1[13:12]);
    s3 = s2[11:0] + 12'(s2[12]);
    return s3;
  endfunction

  function automatic logic [5:0] mod45(input logic [11:0] v);
    logic [24:0] p;
    logic [6:0] q;
    logic [11:0] r;
    p = 25'(v) * 25'(RECIP45);
    q = p[24:18];
    r = v - 12'(12'(q) * 12'd45);
    return r[5:0];
  endfunction

endpackage
`default_nettype wire

FILE: sv/omo_front.sv
// front end: keeps previous counts and forms motion combinations and count sum
`default_nettype none
module omo_front import omo_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     accept,
  input  wire omo_in_t  in_data,
  output omo_job_t      job
);

  logic [31:0] prev_a_r, prev_b_r, prev_c_r;
  logic signed [31:0] da, db, dc;
  logic signed [71:0] cx_w, cy_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r <= '0;
      prev_b_r <= '0;
      prev_c_r <= '0;
    end else if (accept) begin
      prev_a_r <= in_data.count_a;
      prev_b_r <= in_data.count_b;
      prev_c_r <= in_data.count_c;
    end
  end

  always_comb begin
    da = in_data.count_a - prev_a_r;
    db = in_data.count_b - prev_b_r;
    dc = in_data.count_c - prev_c_r;
    cx_w = 72'(da) + 72'(db) - (72'(dc) <<< 1);
    cy_w = 72'(db) - 72'(da);
    job.comb_x = sat32(cx_w);
    job.comb_y = sat32(cy_w);
    job.sum = 34'(in_data.count_a) + 34'(in_data.count_b) + 34'(in_data.count_c);
  end

endmodule
`default_nettype wire

FILE: sv/omo_fifo.sv
// short queue of prepared items between front and back
`default_nettype none
module omo_fifo import omo_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr,
  input  wire omo_job_t wr_data,
  output logic          full,
  input  wire logic     rd,
  output logic          valid,
  output omo_job_t      rd_data
);

  localparam int AW = $clog2(QDEPTH);

  omo_job_t mem_r [QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;
  logic do_wr, do_rd;

  assign full = (cnt_r == (AW+1)'(QDEPTH));
  assign valid = (cnt_r != '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && valid;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == AW'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == AW'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

endmodule
`default_nettype wire

FILE: sv/omo_back.sv
// back end: heading, angle scaling, cordic rotation and position update
`default_nettype none
module omo_back import omo_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire omo_cfg_t cfg,
  input  wire logic     job_valid,
  input  wire omo_job_t job,
  output logic          job_pop,
  output logic          empty,
  input  wire logic     pop,
  output omo_out_t      out_data
);

  omo_state_t state_r, state_nxt;

  logic signed [31:0] cx_r, cy_r, dx_r, dy_r, head_r;
  logic [32:0] ms_r;
  logic neg_r, flip_r;
  logic signed [71:0] prod_r, pa_r;
  logic [65:0] rem_r;
  logic [11:0] fold_r;
  logic [31:0] hm_r, dif_r;
  logic [5:0] cnt_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic signed [42:0] rx_r;
  logic signed [47:0] posx_r, posy_r;
  logic out_valid_r;
  omo_out_t out_r;

  logic signed [35:0] mul_a, mul_b;
  logic [31:0] mc;
  logic [57:0] m_w;
  logic [31:0] msat;
  logic [31:0] q_w;
  logic [31:0] ua;
  logic signed [34:0] cs_w, sn_w;
  logic signed [33:0] xs, ys;
  logic signed [42:0] ry_w;
  logic signed [48:0] nx_w, ny_w;
  logic acc_go;

  assign empty = !out_valid_r;
  assign out_data = out_r;
  assign acc_go = !out_valid_r || pop;

  always_comb begin
    mc = cfg.heading_coef[31] ? 32'(-cfg.heading_coef) : cfg.heading_coef;
    m_w = rem_r[65:8];
    if (neg_r) begin
      msat = (m_w > 58'h8000_0000) ? 32'h8000_0000 : m_w[31:0];
    end else begin
      msat = (m_w > 58'h7FFF_FFFF) ? 32'h7FFF_FFFF : m_w[31:0];
    end
    q_w = prod_r[31:0];
    ua = head_r[31] ? 32'(-q_w) : q_w;
    cs_w = flip_r ? -35'(x_r) : 35'(x_r);
    sn_w = flip_r ? -35'(y_r) : 35'(y_r);
    xs = x_r >>> cnt_r[4:0];
    ys = y_r >>> cnt_r[4:0];
    ry_w = 43'((pa_r + prod_r) >>> 30);
    nx_w = 49'(posx_r) + 49'(rx_r);
    ny_w = 49'(posy_r) + 49'(ry_w);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (job_valid) state_nxt = ST_MX;
      ST_MX: state_nxt = ST_MY;
      ST_MY: state_nxt = ST_H0;
      ST_H0: state_nxt = ST_H1;
      ST_H1: state_nxt = ST_H2;
      ST_H2: state_nxt = (cfg.heading_coef == ONE_Q24) ? ST_HD : ST_MOD;
      ST_MOD: state_nxt = ST_MODR;
      ST_MODR: state_nxt = ST_HD;
      ST_HD: state_nxt = ST_DF;
      ST_DF: state_nxt = ST_DR;
      ST_DR: state_nxt = ST_DM;
      ST_DM: state_nxt = ST_FOLD;
      ST_FOLD: state_nxt = ST_CORD;
      ST_CORD: if (cnt_r == 6'(CORDIC_STEPS-1)) state_nxt = ST_R0;
      ST_R0: state_nxt = ST_R1;
      ST_R1: state_nxt = ST_R2;
      ST_R2: state_nxt = ST_R3;
      ST_R3: state_nxt = ST_ACC;
      ST_ACC: if (acc_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs: queue pop and multiplier operands
  always_comb begin
    job_pop = 1'b0;
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_IDLE: job_pop = job_valid;
      ST_MX: begin
        mul_a = 36'(cx_r);
        mul_b = 36'(cfg.x_coef);
      end
      ST_MY: begin
        mul_a = 36'(cy_r);
        mul_b = 36'(cfg.y_coef);
      end
      ST_H0: begin
        mul_a = {4'b0, mc};
        mul_b = {19'b0, ms_r[16:0]};
      end
      ST_H1: begin
        mul_a = {4'b0, mc};
        mul_b = {20'b0, ms_r[32:17]};
      end
      ST_DM: begin
        mul_a = {4'b0, dif_r};
        mul_b = {4'b0, INV45};
      end
      ST_R0: begin
        mul_a = 36'(dx_r);
        mul_b = 36'(cs_w);
      end
      ST_R1: begin
        mul_a = 36'(dy_r);
        mul_b = 36'(sn_w);
      end
      ST_R2: begin
        mul_a = 36'(dx_r);
        mul_b = 36'(sn_w);
      end
      ST_R3, ST_ACC: begin
        mul_a = 36'(dy_r);
        mul_b = 36'(cs_w);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      posx_r <= '0;
      posy_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_ACC && acc_go) begin
        posx_r <= (nx_w > 49'sh7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF :
                  (nx_w < -49'sh8000_0000_0000) ? 48'sh8000_0000_0000 : nx_w[47:0];
        posy_r <= (ny_w > 49'sh7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF :
                  (ny_w < -49'sh8000_0000_0000) ? 48'sh8000_0000_0000 : ny_w[47:0];
        out_valid_r <= 1'b1;
      end else if (pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      ST_IDLE: begin
        cx_r <= job.comb_x;
        cy_r <= job.comb_y;
        ms_r <= job.sum[33] ? 33'(-job.sum) : job.sum[32:0];
        neg_r <= (job.sum[33] != cfg.heading_coef[31]);
      end
      ST_MY: dx_r <= sat32(prod_r >>> 8);
      ST_H0: dy_r <= sat32(prod_r >>> 8);
      ST_H1: rem_r <= 66'(prod_r);
      ST_H2: rem_r <= rem_r + (66'(prod_r) << 17);
      ST_MOD: fold_r <= fold45(48'(rem_r[63:27]));
      ST_MODR: rem_r <= 66'({mod45(fold_r), rem_r[26:0]});
      ST_HD: begin
        head_r <= neg_r ? 32'(-msat) : msat;
        hm_r <= msat;
      end
      ST_DF: fold_r <= fold45(48'({hm_r, 13'b0}));
      ST_DR: dif_r <= {hm_r[18:0], 13'b0} - 32'(mod45(fold_r));
      ST_FOLD: begin
        flip_r <= ua[31] ^ ua[30];
        z_r <= 34'(signed'({ua[31] ^ (ua[31] ^ ua[30]), ua[30:0]}));
        x_r <= KINV_Q30;
        y_r <= '0;
        cnt_r <= '0;
      end
      ST_CORD: begin
        if (!z_r[33]) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_q(cnt_r[4:0]);
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_q(cnt_r[4:0]);
        end
        cnt_r <= cnt_r + 1'b1;
      end
      ST_R1: pa_r <= prod_r;
      ST_R2: rx_r <= 43'((pa_r - prod_r) >>> 30);
      ST_R3: pa_r <= prod_r;
      ST_ACC: begin
        if (acc_go) begin
          out_r.pos_x <= (nx_w > 49'sh7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF :
                         (nx_w < -49'sh8000_0000_0000) ? 48'sh8000_0000_0000 : nx_w[47:0];
          out_r.pos_y <= (ny_w > 49'sh7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF :
                         (ny_w < -49'sh8000_0000_0000) ? 48'sh8000_0000_0000 : ny_w[47:0];
          out_r.heading <= head_r;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/three_wheel_omni_odometry.sv
// top level of the three wheel omni odometry block
// Dead reckoning for a three wheel omni base. Each item carries three
// absolute encoder counts; the block differences them against the previous
// item, scales the motion, derives the heading and rotates the motion into
// the world frame by a CORDIC before adding it into saturating positions.
// In the back end, an item passes through multiply steps for motion and heading,
// a modulo-360 reduction by residue folding (skipped when heading_coef is
// 1.0), a fold, a subtraction of the residue and a multiply by the inverse of 45
// to turn degrees into a binary angle by exact division, CORDIC_STEPS cordic
// iterations, four rotation products and the position update, with all products
// on one shared multiplier. A two-item queue lets the front accept items while
// the back is busy, and a finished item waits in an output register until popped.
`default_nettype none
module three_wheel_omni_odometry import omo_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire omo_in_t     in_data,
  output logic             empty,
  input  wire logic        pop,
  output omo_out_t         out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [31:0] cfg_data
);

  omo_cfg_t cfg_r;
  omo_job_t front_job, q_job;
  logic q_valid, q_pop, accept;

  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_X_COEF: cfg_r.x_coef <= cfg_data;
        REG_Y_COEF: cfg_r.y_coef <= cfg_data;
        REG_HEAD_COEF: cfg_r.heading_coef <= cfg_data;
        default: ;
      endcase
    end
  end

  omo_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .job     (front_job)
  );

  omo_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (push),
    .wr_data (front_job),
    .full    (full),
    .rd      (q_pop),
    .valid   (q_valid),
    .rd_data (q_job)
  );

  omo_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (q_valid),
    .job       (q_job),
    .job_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> q_valid) else $error("accepted item missing from queue");

  a_full_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> q_valid) else $error("queue full without item");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (empty && !full)) else $error("not clear after reset");

endmodule
`default_nettype wire
